@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: expression does not hold");

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication does not hold");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication does not hold");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ sv/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types, constants and step tables of the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   // Delay counter width and its largest value
   localparam int DELAY_COUNTER_BITS = 16;
   localparam logic [31:0] DELAY_CNT_MAX = 32'((64'd1 << DELAY_COUNTER_BITS) - 64'd1);

   localparam int STEP_BITS = 6;
   localparam logic [15:0] DELAY_RESET = 16'd10;

   typedef enum logic [2:0] {
      OP_START    = 3'd0,
      OP_STOP     = 3'd1,
      OP_SEND     = 3'd2,
      OP_READ     = 3'd3,
      OP_WAIT_ACK = 3'd4,
      OP_ACK      = 3'd5,
      OP_NACK     = 3'd6,
      OP_CHECK    = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      SMP_NONE = 2'd0,
      SMP_DATA = 2'd1,
      SMP_ACK  = 2'd2
   } sample_type;

   // What one program step does to the lines on its first tick
   typedef struct packed {
      logic       scl_set;
      logic       scl_val;
      logic       sda_set;
      logic       sda_val;
      sample_type sample;
      logic       hold;
   } step_action_type;

   localparam step_action_type ACTION_KEEP = '{
      scl_set: 1'b0, scl_val: 1'b0, sda_set: 1'b0, sda_val: 1'b0,
      sample: SMP_NONE, hold: 1'b1
   };

   // Number of steps in each command
   function automatic logic [STEP_BITS-1:0] step_total(op_type op);
      logic [STEP_BITS-1:0] n;
      case (op)
         OP_START:    n = STEP_BITS'(3);
         OP_STOP:     n = STEP_BITS'(2);
         OP_SEND:     n = STEP_BITS'(24);
         OP_READ:     n = STEP_BITS'(16);
         OP_WAIT_ACK: n = STEP_BITS'(3);
         OP_ACK:      n = STEP_BITS'(4);
         OP_NACK:     n = STEP_BITS'(3);
         OP_CHECK:    n = STEP_BITS'(32);
         default:     n = STEP_BITS'(32);
      endcase
      return n;
   endfunction

   function automatic step_action_type plan_start(logic [STEP_BITS-1:0] idx);
      step_action_type a;
      a = ACTION_KEEP;
      if (idx == STEP_BITS'(0)) begin
         a.scl_set = 1'b1; a.scl_val = 1'b1;
         a.sda_set = 1'b1; a.sda_val = 1'b1;
      end else if (idx == STEP_BITS'(1)) begin
         a.sda_set = 1'b1; a.sda_val = 1'b0;
      end else begin
         a.scl_set = 1'b1; a.scl_val = 1'b0;
      end
      return a;
   endfunction

   // Stop: last step releases SDA and does not hold
   function automatic step_action_type plan_stop(logic [STEP_BITS-1:0] idx);
      step_action_type a;
      a = ACTION_KEEP;
      if (idx == STEP_BITS'(0)) begin
         a.sda_set = 1'b1; a.sda_val = 1'b0;
         a.scl_set = 1'b1; a.scl_val = 1'b1;
      end else begin
         a.sda_set = 1'b1; a.sda_val = 1'b1;
         a.hold    = 1'b0;
      end
      return a;
   endfunction

   // Send: three steps per bit (data, SCL high, SCL low); idx below 24
   function automatic step_action_type plan_send(logic [STEP_BITS-1:0] idx,
                                                 logic [7:0] shift);
      step_action_type a;
      logic [8:0]      prod;
      logic [2:0]      bitn;
      logic [4:0]      rem;
      a    = ACTION_KEEP;
      // idx / 3 by reciprocal multiply, exact for idx below 24
      prod = 9'(idx[4:0]) * 9'd11;
      bitn = prod[7:5];
      rem  = idx[4:0] - 5'(5'(bitn) * 5'd3);
      if (rem == 5'd0) begin
         a.sda_set = 1'b1; a.sda_val = shift[~bitn];
      end else if (rem == 5'd1) begin
         a.scl_set = 1'b1; a.scl_val = 1'b1;
      end else begin
         a.scl_set = 1'b1; a.scl_val = 1'b0;
         if (bitn == 3'd7) begin
            a.sda_set = 1'b1; a.sda_val = 1'b1;
         end
      end
      return a;
   endfunction

   // Read: SCL high, then sample and SCL low
   function automatic step_action_type plan_read(logic [STEP_BITS-1:0] idx);
      step_action_type a;
      a = ACTION_KEEP;
      a.scl_set = 1'b1;
      if (!idx[0]) begin
         a.scl_val = 1'b1;
      end else begin
         a.scl_val = 1'b0;
         a.sample  = SMP_DATA;
      end
      return a;
   endfunction

   function automatic step_action_type plan_wait_ack(logic [STEP_BITS-1:0] idx);
      step_action_type a;
      a = ACTION_KEEP;
      if (idx == STEP_BITS'(0)) begin
         a.sda_set = 1'b1; a.sda_val = 1'b1;
      end else if (idx == STEP_BITS'(1)) begin
         a.scl_set = 1'b1; a.scl_val = 1'b1;
      end else begin
         a.scl_set = 1'b1; a.scl_val = 1'b0;
         a.sample  = SMP_ACK;
      end
      return a;
   endfunction

   // Ack / nack: drive level, clock it, release SDA without hold
   function automatic step_action_type plan_ack(logic [STEP_BITS-1:0] idx, logic level);
      step_action_type a;
      a = ACTION_KEEP;
      if (idx == STEP_BITS'(0)) begin
         a.sda_set = 1'b1; a.sda_val = level;
      end else if (idx == STEP_BITS'(1)) begin
         a.scl_set = 1'b1; a.scl_val = 1'b1;
      end else if (idx == STEP_BITS'(2)) begin
         a.scl_set = 1'b1; a.scl_val = 1'b0;
      end else begin
         a.sda_set = 1'b1; a.sda_val = 1'b1;
         a.hold    = 1'b0;
      end
      return a;
   endfunction

   // Action for step idx of a command
   function automatic step_action_type step_plan(op_type op, logic [STEP_BITS-1:0] idx,
                                                 logic [7:0] shift);
      step_action_type a;
      case (op)
         OP_START:    a = plan_start(idx);
         OP_STOP:     a = plan_stop(idx);
         OP_SEND:     a = plan_send(idx, shift);
         OP_READ:     a = plan_read(idx);
         OP_WAIT_ACK: a = plan_wait_ack(idx);
         OP_ACK:      a = plan_ack(idx, 1'b0);
         OP_NACK:     a = plan_ack(idx, 1'b1);
         default: begin
            // check device: start, address byte, wait ack, stop
            if (idx < STEP_BITS'(3)) begin
               a = plan_start(idx);
            end else if (idx < STEP_BITS'(27)) begin
               a = plan_send(idx - STEP_BITS'(3), shift);
            end else if (idx < STEP_BITS'(30)) begin
               a = plan_wait_ack(idx - STEP_BITS'(27));
            end else begin
               a = plan_stop(idx - STEP_BITS'(30));
            end
         end
      endcase
      return a;
   endfunction

endpackage

@@ sv/i2cm_req_if.sv @@
// ----------------------------------------------------------------------------
// i2cm_req_if
// Tick channel into the sequencer: command and sampled SDA.
// ----------------------------------------------------------------------------
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic       command_valid;
   logic [2:0] operation;
   logic [7:0] tx_byte;
   logic       sda_in;

   modport source (output valid, command_valid, operation, tx_byte, sda_in,
                   input ready);
   modport sink   (input valid, command_valid, operation, tx_byte, sda_in,
                   output ready);
endinterface

@@ sv/i2cm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// i2cm_rsp_if
// Result channel out of the sequencer: line drive and status per tick.
// ----------------------------------------------------------------------------
interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       ack_bit;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_bit,
                   input ready);
   modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_bit,
                   output ready);
endinterface

@@ sv/i2cm_csr_if.sv @@
// ----------------------------------------------------------------------------
// i2cm_csr_if
// Configuration write channel carrying the delay_ticks register.
// ----------------------------------------------------------------------------
interface i2cm_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] delay_ticks;

   modport source (output valid, delay_ticks, input ready);
   modport sink   (input valid, delay_ticks, output ready);
endinterface

@@ sv/i2c_master_bit_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master bit sequencer: one bus tick per req transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one bus tick per transaction: an optional command
//   (start, stop, send, read, wait ack, ack, nack, check device), the
//   byte to send and the sampled SDA level. rsp_chan returns one
//   transaction per tick with SCL/SDA drive, busy, done, the last read
//   byte and the last acknowledge. csr_chan writes delay_ticks, the
//   number of ticks each bus phase is held; it is always ready.
//   The tick update is combinational in front of the result register, so
//   a result is registered in the cycle after its tick; one tick is taken
//   every cycle unless a result waits on a stalled receiver: req_chan.ready
//   then stays high only if that result is taken in the same cycle, so no
//   tick is lost. Reset releases both lines, sets the sequencer idle,
//   ack_bit to 1 and delay_ticks to 10. Commands given while busy are ignored.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
   import i2cm_pkg::*;
(
   input logic          clock,
   input logic          reset,
   i2cm_req_if.sink     req_chan,
   i2cm_rsp_if.source   rsp_chan,
   i2cm_csr_if.sink     csr_chan
);

`include "assert_macros.svh"

   // Registers
   logic [15:0]                   delay_ticks_ff;
   logic [STEP_BITS-1:0]          step_ff, step_in;
   logic [DELAY_COUNTER_BITS-1:0] count_ff, count_in;
   logic [7:0]                    shift_ff, shift_in;
   logic [7:0]                    recv_ff, recv_in;
   logic                          ack_ff, ack_in;
   logic                          scl_ff, scl_in;
   logic                          sda_ff, sda_in;
   op_type                        op_ff, op_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic                          req_accept;
   logic                          enter;
   step_action_type               act;
   logic [15:0]                   hold_ticks;
   logic [31:0]                   hold_wide;
   logic [DELAY_COUNTER_BITS-1:0] count_load;

   // Handshakes
   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // Hold length of a waiting step, zero delay acts as one tick
   assign hold_ticks = (delay_ticks_ff == 16'd0) ? 16'd0 : delay_ticks_ff - 16'd1;
   assign hold_wide  = 32'(hold_ticks);
   assign count_load = (hold_wide > DELAY_CNT_MAX) ? DELAY_CNT_MAX[DELAY_COUNTER_BITS-1:0]
                                                   : hold_wide[DELAY_COUNTER_BITS-1:0];

   // Tick update
   always_comb begin
      step_in  = step_ff;
      count_in = count_ff;
      shift_in = shift_ff;
      recv_in  = recv_ff;
      ack_in   = ack_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      op_in    = op_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      enter    = 1'b0;
      act      = ACTION_KEEP;
      if (req_accept) begin
         busy_in = 1'b0;
         done_in = 1'b0;
         if (step_ff == STEP_BITS'(0)) begin
            if (req_chan.command_valid) begin
               op_in    = op_type'(req_chan.operation);
               shift_in = (op_type'(req_chan.operation) == OP_READ) ? 8'd0
                                                                     : req_chan.tx_byte;
               step_in  = STEP_BITS'(1);
               enter    = 1'b1;
            end
         end else if (count_ff != '0) begin
            count_in = count_ff - DELAY_COUNTER_BITS'(1);
         end else begin
            step_in = step_ff + STEP_BITS'(1);
            enter   = 1'b1;
         end

         if (step_in != STEP_BITS'(0)) begin
            busy_in = 1'b1;
            if (enter) begin
               act = step_plan(op_in, step_in - STEP_BITS'(1), shift_in);
               case (act.sample)
                  SMP_DATA: shift_in = {shift_in[6:0], req_chan.sda_in};
                  SMP_ACK:  ack_in   = req_chan.sda_in;
                  default:  ;
               endcase
               if (act.scl_set) begin
                  scl_in = act.scl_val;
               end
               if (act.sda_set) begin
                  sda_in = act.sda_val;
               end
               count_in = act.hold ? count_load : '0;
            end
            // Completion of the command
            if (count_in == '0 && step_in >= step_total(op_in)) begin
               done_in = 1'b1;
               if (op_in == OP_READ) begin
                  recv_in = shift_in;
               end
               step_in = STEP_BITS'(0);
            end
         end
      end
   end

   // Result register valid
   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ticks_ff <= DELAY_RESET;
         step_ff        <= '0;
         count_ff       <= '0;
         shift_ff       <= '0;
         recv_ff        <= '0;
         ack_ff         <= 1'b1;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         op_ff          <= OP_START;
         busy_ff        <= 1'b0;
         done_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            delay_ticks_ff <= csr_chan.delay_ticks;
         end
         step_ff      <= step_in;
         count_ff     <= count_in;
         shift_ff     <= shift_in;
         recv_ff      <= recv_in;
         ack_ff       <= ack_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         op_ff        <= op_in;
         busy_ff      <= busy_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Outputs
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.scl_out  = scl_ff;
   assign rsp_chan.sda_out  = sda_ff;
   assign rsp_chan.busy_res = busy_ff;
   assign rsp_chan.done_res = done_ff;
   assign rsp_chan.rx_byte  = recv_ff;
   assign rsp_chan.ack_bit  = ack_ff;

   // Checks
   `ASSERT_ALWAYS(a_step_range, clock, reset, step_ff <= STEP_BITS'(32))
   `ASSERT_IMPLIES(a_count_idle, clock, reset, count_ff != '0, step_ff != STEP_BITS'(0))
   `ASSERT_IMPLIES(a_no_overrun, clock, reset, rsp_valid_ff && !rsp_chan.ready, !req_chan.ready)
   `ASSERT_NEXT(a_result_after_tick, clock, reset, req_accept, rsp_valid_ff)
   `ASSERT_IMPLIES(a_done_busy, clock, reset, rsp_valid_ff && done_ff, busy_ff)

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C master bit sequencer.
// Every req transaction is one bus tick and yields one rsp transaction. A
// scoreboard runs its own copy of the step sequencer on each accepted tick
// and checks each returned line state against the oldest prediction. The
// run covers a start and a stop at the reset delay, directed commands at
// delay 0 and 1, then random command streams over several delays, the last
// one without idling. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top
   import i2cm_pkg::*;
();

   localparam int LIMIT_CYCLES = 200_000;
   // Steps per command, indexed by operation code
   localparam int STEP_COUNT [8] = '{3, 2, 24, 16, 3, 4, 3, 32};

   // One bus tick as offered on req
   typedef struct packed {
      logic       cmd;
      op_type     op;
      logic [7:0] tx_data;
      logic       sda;
   } tick_type;

   // Line drive and status returned for one tick
   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [7:0] rx;
      logic       ack;
   } line_result_type;

   // What entering one step does to the bus
   typedef struct {
      bit         drive_scl;
      bit         scl_val;
      bit         drive_sda;
      bit         sda_val;
      sample_type grab;
      bit         waits;
   } step_effect_type;

   // -------------------------------------------------------------------------
   // Scoreboard: step sequencer prediction and line state comparison
   // -------------------------------------------------------------------------
   class tick_scoreboard;
      line_result_type expected_lines[$];
      int unsigned  errors, checked, ticks, busy_ticks, started, completed, ignored;
      bit [15:0]    delay_ticks;
      bit [5:0]     step;
      int unsigned  hold_left;
      bit [7:0]     shifter, rx_keep;
      bit           ack_keep, scl_drive, sda_drive;
      op_type       cur_op;

      function new();
         delay_ticks = 16'd10;   // value after reset
         step = 0; hold_left = 0; shifter = 0; rx_keep = 0;
         ack_keep = 1'b1; scl_drive = 1'b1; sda_drive = 1'b1;
         cur_op = OP_START;
         errors = 0; checked = 0; ticks = 0; busy_ticks = 0;
         started = 0; completed = 0; ignored = 0;
      endfunction

      function void set_delay(bit [15:0] v);
         delay_ticks = v;
      endfunction

      function bit idle();
         return step == 0;
      endfunction

      function int pending();
         return expected_lines.size();
      endfunction

      // Effect of one segment (start, stop, byte out, byte in, ack wait, ack/nack)
      function step_effect_type segment_effect(op_type seg, int idx);
         step_effect_type e;
         int           bitn;
         e.drive_scl = 0; e.scl_val = 0; e.drive_sda = 0; e.sda_val = 0;
         e.grab = SMP_NONE; e.waits = 1;
         case (seg)
            OP_START: begin
               if (idx == 0) begin
                  e.drive_scl = 1; e.scl_val = 1; e.drive_sda = 1; e.sda_val = 1;
               end else if (idx == 1) begin
                  e.drive_sda = 1; e.sda_val = 0;
               end else begin
                  e.drive_scl = 1; e.scl_val = 0;
               end
            end
            OP_STOP: begin
               if (idx == 0) begin
                  e.drive_sda = 1; e.sda_val = 0; e.drive_scl = 1; e.scl_val = 1;
               end else begin
                  e.drive_sda = 1; e.sda_val = 1; e.waits = 0;
               end
            end
            OP_SEND: begin
               // three steps per bit: data, SCL high, SCL low
               bitn = idx / 3;
               if (idx % 3 == 0) begin
                  e.drive_sda = 1; e.sda_val = shifter[7 - bitn];
               end else if (idx % 3 == 1) begin
                  e.drive_scl = 1; e.scl_val = 1;
               end else begin
                  e.drive_scl = 1; e.scl_val = 0;
                  if (bitn == 7) begin
                     e.drive_sda = 1; e.sda_val = 1;
                  end
               end
            end
            OP_READ: begin
               e.drive_scl = 1;
               if (idx % 2 == 0) begin
                  e.scl_val = 1;
               end else begin
                  e.scl_val = 0; e.grab = SMP_DATA;
               end
            end
            OP_WAIT_ACK: begin
               if (idx == 0) begin
                  e.drive_sda = 1; e.sda_val = 1;
               end else if (idx == 1) begin
                  e.drive_scl = 1; e.scl_val = 1;
               end else begin
                  e.drive_scl = 1; e.scl_val = 0; e.grab = SMP_ACK;
               end
            end
            default: begin
               // ack and nack differ only in the driven level
               if (idx == 0) begin
                  e.drive_sda = 1; e.sda_val = (seg == OP_NACK);
               end else if (idx == 1) begin
                  e.drive_scl = 1; e.scl_val = 1;
               end else if (idx == 2) begin
                  e.drive_scl = 1; e.scl_val = 0;
               end else begin
                  e.drive_sda = 1; e.sda_val = 1; e.waits = 0;
               end
            end
         endcase
         return e;
      endfunction

      function step_effect_type effect_of(op_type op, int idx);
         if (op != OP_CHECK) return segment_effect(op, idx);
         // check device: start, address byte, ack wait, stop
         if (idx < 3) return segment_effect(OP_START, idx);
         if (idx < 27) return segment_effect(OP_SEND, idx - 3);
         if (idx < 30) return segment_effect(OP_WAIT_ACK, idx - 27);
         return segment_effect(OP_STOP, idx - 30);
      endfunction

      // Advance the sequencer by one accepted tick and queue its line state
      function void note_tick(tick_type t);
         line_result_type r;
         step_effect_type e;
         bit           entered;
         entered = 0;
         r.busy = 0;
         r.done = 0;
         ticks++;
         if (step == 0) begin
            if (t.cmd) begin
               cur_op  = t.op;
               shifter = (t.op == OP_READ) ? 8'h00 : t.tx_data;
               step    = 1;
               entered = 1;
               started++;
            end
         end else begin
            if (t.cmd) ignored++;
            if (hold_left > 0) begin
               hold_left--;
            end else begin
               step++;
               entered = 1;
            end
         end
         if (step != 0) begin
            r.busy = 1;
            busy_ticks++;
            if (entered) begin
               e = effect_of(cur_op, int'(step) - 1);
               if (e.grab == SMP_DATA) shifter = {shifter[6:0], t.sda};
               else if (e.grab == SMP_ACK) ack_keep = t.sda;
               if (e.drive_scl) scl_drive = e.scl_val;
               if (e.drive_sda) sda_drive = e.sda_val;
               // a delay of 0 holds like a delay of 1
               hold_left = (e.waits && delay_ticks > 1) ? delay_ticks - 1 : 0;
            end
            if (hold_left == 0 && step >= STEP_COUNT[int'(cur_op)]) begin
               r.done = 1;
               completed++;
               if (cur_op == OP_READ) rx_keep = shifter;
               step = 0;
            end
         end
         r.scl = scl_drive;
         r.sda = sda_drive;
         r.rx  = rx_keep;
         r.ack = ack_keep;
         expected_lines.push_back(r);
      endfunction

      function void check_result(line_result_type got);
         line_result_type exp;
         checked++;
         if (expected_lines.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: rsp transaction %0d with no tick outstanding", checked);
            return;
         end
         exp = expected_lines.pop_front();
         if (got !== exp) begin
            errors++;
            if (errors <= 10) begin
               $display("ERROR: rsp %0d expected scl=%b sda=%b busy=%b done=%b rx=%02h ack=%b",
                        checked, exp.scl, exp.sda, exp.busy, exp.done, exp.rx, exp.ack);
               $display("       rsp %0d got      scl=%b sda=%b busy=%b done=%b rx=%02h ack=%b",
                        checked, got.scl, got.sda, got.busy, got.done, got.rx, got.ack);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   i2cm_req_if req_chan ();
   i2cm_rsp_if rsp_chan ();
   i2cm_csr_if csr_chan ();

   tick_scoreboard sb = new();

   bit idling_on = 1'b1;
   int gap_pct = 8;
   int tick_mod = 0;
   int stall_left = 0;
   int stall_pct = 8;
   int stall_epoch = 0;
   int delay_writes = 0;
   int cycle_count = 0;

   i2c_master_bit_sequencer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #4 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("ERROR: run limit of %0d cycles reached", LIMIT_CYCLES);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: check each rsp transaction, stall in random bursts
   always @(posedge clock) begin
      line_result_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.scl  = rsp_chan.scl_out;
         got.sda  = rsp_chan.sda_out;
         got.busy = rsp_chan.busy_res;
         got.done = rsp_chan.done_res;
         got.rx   = rsp_chan.rx_byte;
         got.ack  = rsp_chan.ack_bit;
         sb.check_result(got);
      end
      stall_epoch++;
      if (stall_epoch % 64 == 0)
         stall_pct = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 6 : 25);
      if (stall_left > 0)
         stall_left--;
      else if (idling_on && $urandom_range(0, 99) < stall_pct)
         stall_left = $urandom_range(1, 10);
      rsp_chan.ready <= (stall_left == 0);
   end

   // Offer one tick and wait for its req transaction
   task automatic drive_tick(tick_type t);
      req_chan.valid         <= 1'b1;
      req_chan.command_valid <= t.cmd;
      req_chan.operation     <= t.op;
      req_chan.tx_byte       <= t.tx_data;
      req_chan.sda_in        <= t.sda;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_tick(t);
   endtask

   // Sender idle burst, with stretches of no idling
   task automatic maybe_gap();
      tick_mod++;
      if (tick_mod % 40 == 0)
         gap_pct = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 8 : 30);
      if (idling_on && $urandom_range(0, 99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Mostly commands when idle, occasional ignored commands when busy
   function automatic tick_type random_tick(bit seq_idle);
      tick_type t;
      t.sda     = 1'($urandom_range(0, 1));
      t.tx_data = 8'($urandom_range(0, 255));
      t.op      = op_type'($urandom_range(0, 7));
      t.cmd     = seq_idle ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) < 2);
      return t;
   endfunction

   // sda_mode: 0 low, 1 high, 2 random; pester puts a command on every busy tick
   task automatic tick_until_idle(bit [1:0] sda_mode, bit pester);
      tick_type t;
      while (!sb.idle()) begin
         t     = random_tick(1'b0);
         t.cmd = pester;
         t.sda = (sda_mode == 2'd2) ? 1'($urandom_range(0, 1)) : sda_mode[0];
         drive_tick(t);
         maybe_gap();
      end
   endtask

   task automatic run_command(op_type op, bit [7:0] data, bit [1:0] sda_mode, bit pester);
      tick_type t;
      t.cmd     = 1'b1;
      t.op      = op;
      t.tx_data = data;
      t.sda     = (sda_mode == 2'd2) ? 1'($urandom_range(0, 1)) : sda_mode[0];
      drive_tick(t);
      maybe_gap();
      tick_until_idle(sda_mode, pester);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Register write once every result is back
   task automatic write_delay(bit [15:0] v);
      drain_results();
      csr_chan.valid       <= 1'b1;
      csr_chan.delay_ticks <= v;
      do @(posedge clock); while (!csr_chan.ready);
      sb.set_delay(v);
      csr_chan.valid <= 1'b0;
      delay_writes++;
   endtask

   // Random command stream until enough busy ticks, then let the command end
   task automatic random_phase(int busy_target);
      int unsigned start_busy;
      start_busy = sb.busy_ticks;
      while (sb.busy_ticks - start_busy < busy_target) begin
         drive_tick(random_tick(sb.idle()));
         maybe_gap();
      end
      tick_until_idle(2'd2, 1'b0);
   endtask

   initial begin
      int delays [6];
      delays                  = '{2, 1, 3, 0, 5, 1};
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.command_valid <= 1'b0;
      req_chan.operation     <= OP_START;
      req_chan.tx_byte       <= 8'h00;
      req_chan.sda_in        <= 1'b1;
      csr_chan.valid         <= 1'b0;
      csr_chan.delay_ticks   <= 16'd10;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Start and stop at the reset delay
      run_command(OP_START, 8'h00, 2'd2, 1'b1);
      run_command(OP_STOP, 8'h00, 2'd2, 1'b0);

      // Zero delay behaves as one tick
      write_delay(16'd0);
      run_command(OP_START, 8'h00, 2'd2, 1'b0);
      run_command(OP_READ, 8'h00, 2'd2, 1'b0);
      run_command(OP_CHECK, 8'h5A, 2'd2, 1'b1);
      run_command(OP_STOP, 8'h00, 2'd2, 1'b0);

      // Every command but start at delay 1
      write_delay(16'd1);
      run_command(OP_SEND, 8'hFF, 2'd2, 1'b1);
      run_command(OP_SEND, 8'hA5, 2'd2, 1'b0);
      run_command(OP_WAIT_ACK, 8'h00, 2'd0, 1'b0);
      run_command(OP_WAIT_ACK, 8'h00, 2'd1, 1'b0);
      run_command(OP_READ, 8'hFF, 2'd1, 1'b0);
      run_command(OP_READ, 8'h00, 2'd0, 1'b1);
      run_command(OP_ACK, 8'h00, 2'd2, 1'b0);
      run_command(OP_NACK, 8'h00, 2'd2, 1'b1);
      run_command(OP_CHECK, 8'h00, 2'd0, 1'b0);
      run_command(OP_CHECK, 8'hFF, 2'd1, 1'b1);
      run_command(OP_STOP, 8'h00, 2'd2, 1'b0);

      // Random streams over several delays, the last one without idling
      foreach (delays[i]) begin
         write_delay(16'(delays[i]));
         if (i == 5) idling_on = 1'b0;
         random_phase(15);
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.errors++;
         $display("ERROR: %0d line states never returned", sb.pending());
      end

      $display("Ran %0d ticks (%0d busy): %0d commands started, %0d done, %0d ignored.",
               sb.ticks, sb.busy_ticks, sb.started, sb.completed, sb.ignored);
      $display("%0d delay writes (0 and 1 among them), %0d mismatching results.",
               delay_writes, sb.errors);
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
